// ----- src/htc_pkg.sv -----
package htc_pkg;

  // Action codes carried by an input beat
  localparam logic [1:0] ACT_CHECK = 2'd0;
  localparam logic [1:0] ACT_ON    = 2'd1;
  localparam logic [1:0] ACT_OFF   = 2'd2;

  // Mode codes shown on the result channel
  localparam logic [1:0] MODE_OFF     = 2'd0;
  localparam logic [1:0] MODE_HEAT    = 2'd1;
  localparam logic [1:0] MODE_REACHED = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_HEAT_HYST   = 2'd0;
  localparam logic [1:0] CFG_COOL_HYST   = 2'd1;
  localparam logic [1:0] CFG_ALARM_DELAY = 2'd2;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned HYST_W     = 15;
  localparam int unsigned TEMP_W     = 16;
  localparam int unsigned ELAPSED_W  = 16;
  localparam int unsigned TOTAL_W    = 32;

  // Alarm threshold in ms: 65535 s * 1000 fits in 26 bits
  localparam int unsigned MS_PER_S   = 1000;
  localparam int unsigned ALARM_THR_W = 26;

endpackage

// ----- src/htc_if.sv -----
interface htc_in_if;
  import htc_pkg::*;

  logic                        valid;
  logic                        ready;
  logic [1:0]                  action;
  logic signed [TEMP_W-1:0]    temperature;
  logic signed [TEMP_W-1:0]    setpoint;
  logic [ELAPSED_W-1:0]        elapsed_ms;

  modport source (output valid, action, temperature, setpoint, elapsed_ms, input ready);
  modport sink   (input valid, action, temperature, setpoint, elapsed_ms, output ready);
endinterface

interface htc_out_if;
  import htc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [1:0]           mode;
  logic                 heater_drive;
  logic                 reached_flag;
  logic                 not_reached_alarm;
  logic [TOTAL_W-1:0]   total_heat_ms;

  modport source (output valid, mode, heater_drive, reached_flag, not_reached_alarm,
                  total_heat_ms, input ready);
  modport sink   (input valid, mode, heater_drive, reached_flag, not_reached_alarm,
                  total_heat_ms, output ready);
endinterface

interface htc_cfg_if;
  import htc_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [CFG_IDX_W-1:0]   index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/heater_hysteresis_controller.sv -----
// Heater hysteresis controller: a three-mode thermostat (off, heating, setpoint
// reached). Each input beat (check tick, switch-on or switch-off command) yields
// exactly one result beat with the mode after that beat, the heater drive, the
// sticky reached flag, the sticky heating-timeout alarm and the saturating total
// heating time in ms. The block takes one beat per clock cycle while results are
// taken; each beat sits in the input register, then updates the controller
// state, which doubles as the result register. Back-pressure on the result
// channel stalls the input register, which itself frees one beat of slack so a
// new input beat is taken while a result waits. Configuration writes are always
// accepted and must be issued only while the block is idle; the alarm delay is
// converted to ms when written.
module heater_hysteresis_controller (
  input  logic      clk,
  input  logic      rst_n,
  htc_in_if.sink    in_ch,
  htc_out_if.source out_ch,
  htc_cfg_if.sink   cfg_ch
);
  import htc_pkg::*;

  typedef enum logic [1:0] {
    ST_OFF     = MODE_OFF,
    ST_HEAT    = MODE_HEAT,
    ST_REACHED = MODE_REACHED
  } state_t;

  localparam int unsigned MARK_W = TEMP_W + 2;

  function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] a,
                                                input logic [TOTAL_W-1:0] b);
    logic [TOTAL_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TOTAL_W] ? '1 : s[TOTAL_W-1:0];
  endfunction

  // Configuration
  logic [HYST_W-1:0]      heat_hyst_r;
  logic [HYST_W-1:0]      cool_hyst_r;
  logic [ALARM_THR_W-1:0] alarm_thr_r;

  // Input register
  logic                     in_vld_r;
  logic [1:0]               in_act_r;
  logic signed [TEMP_W-1:0] in_temp_r;
  logic signed [TEMP_W-1:0] in_sp_r;
  logic [ELAPSED_W-1:0]     in_el_r;

  // Controller state, also the result register
  logic               out_vld_r;
  state_t             mode_r, mode_nxt;
  logic [TOTAL_W-1:0] tc_r, tc_nxt;
  logic [TOTAL_W-1:0] on_r, on_nxt;
  logic [TOTAL_W-1:0] tot_r, tot_nxt;
  logic               reached_r, reached_nxt;
  logic               alarm_r, alarm_nxt;

  logic                     adv;
  logic                     in_take;
  logic signed [MARK_W-1:0] temp_x;
  logic signed [MARK_W-1:0] hi_mark;
  logic signed [MARK_W-1:0] lo_mark;
  logic                     above;
  logic                     below;
  logic [TOTAL_W-1:0]       tc_acc;
  logic [TOTAL_W-1:0]       on_acc;

  // Advance the input register into the state whenever the result slot is free
  assign adv     = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_take = in_ch.valid && in_ch.ready;

  assign in_ch.ready  = !in_vld_r || adv;
  assign cfg_ch.ready = 1'b1;

  // Compare at full precision: setpoint plus or minus a margin never wraps
  assign temp_x  = {{2{in_temp_r[TEMP_W-1]}}, in_temp_r};
  assign hi_mark = {{2{in_sp_r[TEMP_W-1]}}, in_sp_r} + {3'b000, heat_hyst_r};
  assign lo_mark = {{2{in_sp_r[TEMP_W-1]}}, in_sp_r} - {3'b000, cool_hyst_r};
  assign above   = temp_x > hi_mark;
  assign below   = temp_x < lo_mark;

  assign tc_acc = sat_add(tc_r, TOTAL_W'(in_el_r));
  assign on_acc = sat_add(on_r, TOTAL_W'(in_el_r));

  always_comb begin
    mode_nxt    = mode_r;
    tc_nxt      = tc_r;
    on_nxt      = on_r;
    tot_nxt     = tot_r;
    reached_nxt = reached_r;
    alarm_nxt   = alarm_r;
    case (in_act_r)
      ACT_CHECK: begin
        // Advance time first, then decide the transition
        tc_nxt = tc_acc;
        on_nxt = on_acc;
        unique case (mode_r)
          ST_OFF: begin
            tc_nxt = '0;
          end
          ST_HEAT: begin
            if (above) begin
              tot_nxt     = sat_add(tot_r, on_acc);
              mode_nxt    = ST_REACHED;
              reached_nxt = 1'b1;
            end
          end
          ST_REACHED: begin
            if (below) begin
              mode_nxt = ST_HEAT;
              on_nxt   = '0;
              tc_nxt   = '0;
            end else begin
              reached_nxt = 1'b1;
              tc_nxt      = '0;
            end
          end
          default: ;
        endcase
        // Timeout test runs in the mode that results from this tick
        if (mode_nxt == ST_HEAT && tc_nxt >= TOTAL_W'(alarm_thr_r)) begin
          alarm_nxt = 1'b1;
        end
      end
      ACT_ON: begin
        if (mode_r == ST_OFF) begin
          if (above) begin
            mode_nxt    = ST_REACHED;
            reached_nxt = 1'b1;
          end else begin
            mode_nxt = ST_HEAT;
            on_nxt   = '0;
            tc_nxt   = '0;
          end
        end
      end
      ACT_OFF: begin
        if (mode_r == ST_HEAT) begin
          tot_nxt  = sat_add(tot_r, on_r);
          mode_nxt = ST_OFF;
        end else if (mode_r == ST_REACHED) begin
          mode_nxt = ST_OFF;
        end
      end
      default: ;  // unused code: hold everything, still report
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      mode_r    <= ST_OFF;
      tc_r      <= '0;
      on_r      <= '0;
      tot_r     <= '0;
      reached_r <= 1'b0;
      alarm_r   <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        in_vld_r <= in_ch.valid;
      end
      if (in_take) begin
        in_act_r  <= in_ch.action;
        in_temp_r <= in_ch.temperature;
        in_sp_r   <= in_ch.setpoint;
        in_el_r   <= in_ch.elapsed_ms;
      end
      if (adv) begin
        out_vld_r <= 1'b1;
        mode_r    <= mode_nxt;
        tc_r      <= tc_nxt;
        on_r      <= on_nxt;
        tot_r     <= tot_nxt;
        reached_r <= reached_nxt;
        alarm_r   <= alarm_nxt;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Configuration writes; convert the alarm delay to ms once, here
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heat_hyst_r <= '0;
      cool_hyst_r <= '0;
      alarm_thr_r <= '0;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.index)
        CFG_HEAT_HYST:   heat_hyst_r <= cfg_ch.data[HYST_W-1:0];
        CFG_COOL_HYST:   cool_hyst_r <= cfg_ch.data[HYST_W-1:0];
        CFG_ALARM_DELAY: alarm_thr_r <= ALARM_THR_W'(cfg_ch.data) * ALARM_THR_W'(MS_PER_S);
        default: ;
      endcase
    end
  end

  assign out_ch.valid             = out_vld_r;
  assign out_ch.mode              = mode_r;
  assign out_ch.heater_drive      = (mode_r == ST_HEAT);
  assign out_ch.reached_flag      = reached_r;
  assign out_ch.not_reached_alarm = alarm_r;
  assign out_ch.total_heat_ms     = tot_r;

endmodule

// ----- src/htc_checker.sv -----
module htc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_mode,
  input logic        out_reached_flag,
  input logic        out_alarm,
  input logic [31:0] out_total
);
  logic        beat;
  logic        seen_beat_r;
  logic        seen_reached_r;
  logic        seen_alarm_r;
  logic [31:0] last_total_r;

  assign beat = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_beat_r    <= 1'b0;
      seen_reached_r <= 1'b0;
      seen_alarm_r   <= 1'b0;
      last_total_r   <= '0;
    end else if (beat) begin
      seen_beat_r    <= 1'b1;
      seen_reached_r <= seen_reached_r || out_reached_flag;
      seen_alarm_r   <= seen_alarm_r || out_alarm;
      last_total_r   <= out_total;
    end
  end

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_reached_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    beat && seen_reached_r |-> out_reached_flag)
    else $error("reached flag dropped");

  a_alarm_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    beat && seen_alarm_r |-> out_alarm)
    else $error("alarm dropped");

  a_total_grows: assert property (@(posedge clk) disable iff (!rst_n)
    beat && seen_beat_r |-> out_total >= last_total_r)
    else $error("total heating time decreased");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_mode) && $stable(out_total))
    else $error("stalled result changed");

endmodule

bind heater_hysteresis_controller htc_checker u_htc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_mode         (out_ch.mode),
  .out_reached_flag (out_ch.reached_flag),
  .out_alarm        (out_ch.not_reached_alarm),
  .out_total        (out_ch.total_heat_ms)
);

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import htc_pkg::*;

  // Action code 3 has no meaning to the block; it must be ignored
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam int DRAIN_CYCLES = 6;
  localparam int CYCLE_LIMIT  = 100000;
  localparam int PRINT_CAP    = 60;

  typedef struct packed {
    logic [1:0]           action;
    logic signed [15:0]   temperature;
    logic signed [15:0]   setpoint;
    logic [15:0]          elapsed_ms;
  } thermo_cmd_t;

  typedef struct packed {
    logic [1:0]   mode;
    logic         heater_drive;
    logic         reached_flag;
    logic         not_reached_alarm;
    logic [31:0]  total_heat_ms;
  } thermo_status_t;

  logic clk;
  logic rst_n;

  htc_in_if  in_if ();
  htc_out_if out_if ();
  htc_cfg_if cfg_if ();

  heater_hysteresis_controller dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Commands waiting for the driver, and status beats the block still owes us
  thermo_cmd_t    cmd_q[$];
  thermo_status_t status_q[$];

  int unsigned cmds_queued;
  int unsigned status_seen;
  int unsigned fail_count;
  int unsigned cycle_count;
  bit          full_speed;

  // Thermostat mirror: configuration as the block holds it
  int          heat_margin;
  int          cool_margin;
  logic [31:0] alarm_limit_ms;

  // Thermostat mirror: controller state
  logic [1:0]  mirror_mode;
  logic [31:0] mirror_timeout_ms;
  logic [31:0] mirror_on_ms;
  logic [31:0] mirror_total_ms;
  logic        mirror_reached;
  logic        mirror_alarm;

  function automatic logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // Advance the mirror by one accepted command and return the status it shows
  function automatic thermo_status_t step_thermostat(thermo_cmd_t c);
    int             t;
    int             s;
    logic           above;
    logic           below;
    thermo_status_t r;
    t = int'($signed(c.temperature));
    s = int'($signed(c.setpoint));
    // compare in 32-bit ints so setpoint +/- margin never wraps
    above = t > s + heat_margin;
    below = t < s - cool_margin;
    case (c.action)
      ACT_CHECK: begin
        mirror_timeout_ms = sat_sum(mirror_timeout_ms, {16'd0, c.elapsed_ms});
        mirror_on_ms      = sat_sum(mirror_on_ms, {16'd0, c.elapsed_ms});
        if (mirror_mode == MODE_OFF) begin
          mirror_timeout_ms = '0;
        end else if (mirror_mode == MODE_HEAT) begin
          if (above) begin
            mirror_total_ms = sat_sum(mirror_total_ms, mirror_on_ms);
            mirror_mode     = MODE_REACHED;
            mirror_reached  = 1'b1;
          end
        end else if (below) begin
          mirror_mode       = MODE_HEAT;
          mirror_on_ms      = '0;
          mirror_timeout_ms = '0;
        end else begin
          mirror_reached    = 1'b1;
          mirror_timeout_ms = '0;
        end
        // timeout is judged in the mode the check lands in
        if (mirror_mode == MODE_HEAT && mirror_timeout_ms >= alarm_limit_ms)
          mirror_alarm = 1'b1;
      end
      ACT_ON: begin
        if (mirror_mode == MODE_OFF) begin
          if (above) begin
            mirror_mode    = MODE_REACHED;
            mirror_reached = 1'b1;
          end else begin
            mirror_mode       = MODE_HEAT;
            mirror_on_ms      = '0;
            mirror_timeout_ms = '0;
          end
        end
      end
      ACT_OFF: begin
        if (mirror_mode == MODE_HEAT) begin
          mirror_total_ms = sat_sum(mirror_total_ms, mirror_on_ms);
          mirror_mode     = MODE_OFF;
        end else if (mirror_mode == MODE_REACHED) begin
          mirror_mode = MODE_OFF;
        end
      end
      default: ;
    endcase
    r.mode              = mirror_mode;
    r.heater_drive      = (mirror_mode == MODE_HEAT);
    r.reached_flag      = mirror_reached;
    r.not_reached_alarm = mirror_alarm;
    r.total_heat_ms     = mirror_total_ms;
    return r;
  endfunction

  // Print one line per mismatch (capped to keep the log short) and count it
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (fail_count < PRINT_CAP)
      $display("[%0t] MISMATCH %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    fail_count++;
  endtask

  task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch(what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: pop commands in bursts of random length, with random gaps between.
  // Hold the beat while ready is low; predict the status on acceptance.
  // ---------------------------------------------------------------------------
  thermo_cmd_t drv_cmd;
  int          burst_left;
  int          gap_left;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      burst_left = 1;
      gap_left   = 0;
    end else begin
      if (in_if.valid && in_if.ready)
        status_q.push_back(step_thermostat(drv_cmd));
      if (!in_if.valid || in_if.ready) begin
        if (gap_left > 0 && !full_speed) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (cmd_q.size() != 0) begin
          drv_cmd = cmd_q.pop_front();
          in_if.valid       <= 1'b1;
          in_if.action      <= drv_cmd.action;
          in_if.temperature <= drv_cmd.temperature;
          in_if.setpoint    <= drv_cmd.setpoint;
          in_if.elapsed_ms  <= drv_cmd.elapsed_ms;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            // about a quarter of bursts run straight into the next one
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: ready follows a rotating 8-bit pattern, periodically reloaded.
  // Compare each accepted status beat against the oldest prediction.
  // ---------------------------------------------------------------------------
  thermo_status_t mon_want;
  logic [7:0]     ready_pattern;
  int unsigned    pattern_age;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      ready_pattern = 8'hFF;
      pattern_age   = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        status_seen++;
        if (status_q.size() == 0) begin
          report_mismatch("status beat with nothing expected", 32'(out_if.mode), '0);
        end else begin
          mon_want = status_q.pop_front();
          check_field("mode", 32'(out_if.mode), 32'(mon_want.mode));
          check_field("heater_drive", 32'(out_if.heater_drive),
                      32'(mon_want.heater_drive));
          check_field("reached_flag", 32'(out_if.reached_flag),
                      32'(mon_want.reached_flag));
          check_field("not_reached_alarm", 32'(out_if.not_reached_alarm),
                      32'(mon_want.not_reached_alarm));
          check_field("total_heat_ms", out_if.total_heat_ms, mon_want.total_heat_ms);
        end
      end
      pattern_age++;
      if (pattern_age % 32 == 0) begin
        case ($urandom_range(0, 3))
          0:       ready_pattern = 8'hFF;
          1:       ready_pattern = 8'h01;
          2:       ready_pattern = 8'h3C;
          default: ready_pattern = 8'($urandom) | 8'h01;
        endcase
      end else begin
        ready_pattern = {ready_pattern[0], ready_pattern[7:1]};
      end
      out_if.ready <= full_speed ? 1'b1 : ready_pattern[0];
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_cmd(logic [1:0] act, int temp, int sp, int elapsed);
    thermo_cmd_t c;
    c.action      = act;
    c.temperature = 16'(temp);
    c.setpoint    = 16'(sp);
    c.elapsed_ms  = 16'(elapsed);
    cmd_q.push_back(c);
    cmds_queued++;
  endtask

  // Pick a temperature around the hysteresis band of a setpoint, clamped
  function automatic int near_temp(int sp);
    int lo;
    int hi;
    int v;
    lo = sp - cool_margin - 3;
    hi = sp + heat_margin + 3;
    v  = lo + int'($urandom_range(0, hi - lo));
    if (v < -32768) v = -32768;
    if (v > 32767)  v = 32767;
    return v;
  endfunction

  function automatic int pick_setpoint();
    case ($urandom_range(0, 7))
      0:       return -32768;
      1:       return 32767;
      default: return int'($signed(16'($urandom)));
    endcase
  endfunction

  function automatic int pick_elapsed();
    return ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 65535))
                                       : int'($urandom_range(0, 1500));
  endfunction

  // Write one register and mirror it once the beat is taken
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      CFG_HEAT_HYST:   heat_margin    = int'(val[14:0]);
      CFG_COOL_HYST:   cool_margin    = int'(val[14:0]);
      CFG_ALARM_DELAY: alarm_limit_ms = 32'(val) * MS_PER_S;
      default: ;
    endcase
  endtask

  // Hysteresis registers are 15 bits: toggle the unused top bit of the write too
  task automatic apply_settings(int heat, int cool, int delay_s);
    write_reg(CFG_HEAT_HYST, {1'($urandom_range(0, 1)), 15'(heat)});
    write_reg(CFG_COOL_HYST, {1'($urandom_range(0, 1)), 15'(cool)});
    write_reg(CFG_ALARM_DELAY, 16'(delay_s));
  endtask

  // Stall the sender until every predicted status has come back, then let
  // the pipeline settle so the block is idle for a configuration write.
  task automatic wait_idle();
    while (status_seen < cmds_queued) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Mostly well-formed sessions: switch on, a run of checks around the band,
  // usually a switch off. Sprinkle fully random beats in as noise.
  task automatic push_random_phase(int budget);
    int made;
    int sp;
    int k;
    logic [1:0] act;
    made = 0;
    while (made < budget) begin
      sp = pick_setpoint();
      push_cmd(ACT_ON, near_temp(sp), sp, pick_elapsed());
      made++;
      k = $urandom_range(1, 12);
      repeat (k) begin
        if ($urandom_range(0, 9) == 0) begin
          act = 2'($urandom_range(0, 3));
          push_cmd(act, int'($signed(16'($urandom))), int'($signed(16'($urandom))),
                   int'($urandom_range(0, 65535)));
          if (act != ACT_UNUSED) made++;
        end else begin
          // let the setpoint drift now and then so crossings come from both sides
          if ($urandom_range(0, 7) == 0) sp = pick_setpoint();
          push_cmd(ACT_CHECK, near_temp(sp), sp, pick_elapsed());
          made++;
        end
      end
      if ($urandom_range(0, 2) != 0) begin
        push_cmd(ACT_OFF, near_temp(sp), sp, pick_elapsed());
        made++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    clk               = 1'b0;
    rst_n             = 1'b0;
    in_if.valid       = 1'b0;
    in_if.action      = ACT_CHECK;
    in_if.temperature = '0;
    in_if.setpoint    = '0;
    in_if.elapsed_ms  = '0;
    out_if.ready      = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = CFG_HEAT_HYST;
    cfg_if.data       = '0;
    full_speed        = 1'b0;
    cmds_queued       = 0;
    status_seen       = 0;
    fail_count        = 0;
    cycle_count       = 0;

    heat_margin       = 0;
    cool_margin       = 0;
    alarm_limit_ms    = '0;
    mirror_mode       = MODE_OFF;
    mirror_timeout_ms = '0;
    mirror_on_ms      = '0;
    mirror_total_ms   = '0;
    mirror_reached    = 1'b0;
    mirror_alarm      = 1'b0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: heat band of 10, cool band of 20, alarm after 2000 ms
    apply_settings(10, 20, 2);
    push_cmd(ACT_CHECK, 0, 0, 65535);              // check while off clears timeout
    push_cmd(ACT_UNUSED, 32767, -32768, 65535);    // unused code changes nothing
    push_cmd(ACT_OFF, 0, 0, 0);                    // off while off is ignored
    push_cmd(ACT_ON, -32768, 32767, 0);            // cold start enters heating
    push_cmd(ACT_ON, 32767, -32768, 65535);        // on while heating is ignored
    push_cmd(ACT_CHECK, 100, 100, 1000);
    push_cmd(ACT_CHECK, 110, 100, 1000);           // exactly on the mark; alarm hits limit
    push_cmd(ACT_CHECK, 111, 100, 500);            // one above the mark reaches
    push_cmd(ACT_ON, 0, 0, 0);                     // on while reached is ignored
    push_cmd(ACT_CHECK, 80, 100, 700);             // on the cool edge: stay reached
    push_cmd(ACT_CHECK, 79, 100, 0);               // below the cool edge: heat again
    push_cmd(ACT_UNUSED, 0, 0, 0);
    push_cmd(ACT_OFF, 0, 0, 0);
    push_cmd(ACT_ON, 32767, -32768, 0);            // already warm: straight to reached
    push_cmd(ACT_OFF, 0, 0, 0);
    push_cmd(ACT_OFF, 0, 0, 0);
    push_cmd(ACT_ON, 110, 100, 0);                 // on the mark is not above it
    push_cmd(ACT_CHECK, 32767, -32768, 65535);     // widest gap with no wrap
    push_cmd(ACT_CHECK, -32768, 32767, 1);
    push_cmd(ACT_CHECK, -32768, 32767, 65535);
    push_cmd(ACT_OFF, 0, 0, 0);
    wait_idle();

    // Random phases across register settings, extremes included
    apply_settings(0, 0, 0);
    push_random_phase(220);
    wait_idle();

    apply_settings(32767, 32767, 65535);
    push_random_phase(220);
    wait_idle();

    apply_settings(1, 1, 1);
    push_random_phase(220);
    wait_idle();

    apply_settings($urandom_range(0, 40), $urandom_range(0, 40), $urandom_range(0, 2));
    push_random_phase(220);
    wait_idle();

    apply_settings($urandom_range(0, 32767), $urandom_range(0, 32767),
                   $urandom_range(0, 65535));
    push_random_phase(220);
    wait_idle();

    apply_settings(32767, 0, 0);
    push_random_phase(220);
    wait_idle();

    apply_settings(0, 32767, $urandom_range(0, 5));
    push_random_phase(220);
    wait_idle();

    // Long heating run with the widest steps and the longest alarm delay,
    // back to back with no idling on either side.
    apply_settings(0, 0, 65535);
    full_speed = 1'b1;
    push_cmd(ACT_ON, -32768, 32767, 0);
    repeat (20) push_cmd(ACT_CHECK, -32768, 32767, 65535);
    push_cmd(ACT_OFF, 0, 0, 0);
    push_cmd(ACT_ON, -32768, 32767, 0);
    push_cmd(ACT_CHECK, -32768, 32767, 65535);
    push_cmd(ACT_OFF, 0, 0, 0);
    wait_idle();
    full_speed = 1'b0;

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (status_q.size() != 0)
      report_mismatch("predicted status beats never seen", status_q.size(), 0);

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
